>>> rtl/core/ax25_frame_decoder_assert.svh
// Assertion macros shared by the checker of the AX.25 frame decoder.
`ifndef AX25_FRAME_DECODER_ASSERT_SVH
`define AX25_FRAME_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AX25FD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AX25FD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ax25fd_pkg.sv
// Package of the AX.25 frame decoder: codes, result type and the CRC byte update.
package ax25fd_pkg;

    localparam int unsigned MAX_ADDRS_DEF = 10;
    localparam int unsigned MAX_INFO_DEF  = 256;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_XOR  = 16'hFFFF;

    localparam logic [4:0] MIN_FRAME_BYTES = 5'd18;

    localparam logic [2:0] KIND_CALL   = 3'd0;
    localparam logic [2:0] KIND_SSID   = 3'd1;
    localparam logic [2:0] KIND_CTRL   = 3'd2;
    localparam logic [2:0] KIND_PID    = 3'd3;
    localparam logic [2:0] KIND_INFO   = 3'd4;
    localparam logic [2:0] KIND_STATUS = 3'd5;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
    localparam logic [2:0] ST_BAD_CHECK  = 3'd2;
    localparam logic [2:0] ST_BAD_ADDR   = 3'd3;
    localparam logic [2:0] ST_NO_CTRL    = 3'd4;
    localparam logic [2:0] ST_INFO_LONG  = 3'd5;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic [3:0] addr_index;
        logic [3:0] ssid;
        logic       repeated;
        logic       addr_last;
        logic [2:0] status;
        logic [3:0] addr_total;
        logic [8:0] info_length;
        logic       run_last;
    } result_t;

    // Reflected CRC-16 update over one byte, least significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/ax25fd_byte_if.sv
// Channel interface carrying received frame bytes into the decoder.
interface ax25fd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

>>> rtl/core/ax25fd_item_if.sv
// Channel interface carrying decoded result items out of the decoder.
interface ax25fd_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] value;
    logic [3:0] addr_index;
    logic [3:0] ssid;
    logic       repeated;
    logic       addr_last;
    logic [2:0] status;
    logic [3:0] addr_total;
    logic [8:0] info_length;
    logic       run_last;

    modport source (output valid, output kind, output value, output addr_index,
                    output ssid, output repeated, output addr_last, output status,
                    output addr_total, output info_length, output run_last,
                    input ready);
    modport sink (input valid, input kind, input value, input addr_index,
                  input ssid, input repeated, input addr_last, input status,
                  input addr_total, input info_length, input run_last,
                  output ready);
endinterface

>>> rtl/core/ax25_frame_decoder.sv
// AX.25 frame decoder: byte classification, CRC-16/X.25 check and frame status.
//
// byte_chan takes the unstuffed bytes of a frame, one per transfer, with
// frame_end set on the last byte. item_chan delivers result items: callsign
// characters, SSID bytes, control, PID and info bytes, and one status item per
// frame. A byte leaves a two-byte delay line, so its item is written when the
// byte two positions later is accepted and shows on item_chan the next cycle
// if the queue was empty. The status item is written with the frame_end
// transfer, behind the payload item that the same transfer writes, if any.
// The consumer drops a frame's items unless its status is ok.
// Throughput is one byte per cycle while byte_chan is ready. The CRC update,
// classification and the end-of-frame checks sit in one combinational stage in
// front of a four-entry result queue, so a byte causes up to two queue writes in
// the cycle it is accepted. byte_chan is ready while at most two items wait in
// the queue; a stalled receiver therefore stops byte_chan once three or four
// items wait. The frame_end byte writes up to two items: the payload item of the
// oldest held byte, if any, and the status item.
// Reset empties the queue and returns the parser to the address phase with the
// CRC preset to all ones.
module ax25_frame_decoder #(
    parameter int unsigned MAX_ADDRS = ax25fd_pkg::MAX_ADDRS_DEF,
    parameter int unsigned MAX_INFO  = ax25fd_pkg::MAX_INFO_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ax25fd_byte_if.sink          byte_chan,
    ax25fd_item_if.source        item_chan
);

    localparam int unsigned ICW = $clog2(MAX_INFO + 2);
    localparam logic [ICW-1:0] INFO_LIMIT = ICW'(MAX_INFO);
    localparam logic [ICW-1:0] INFO_SAT   = ICW'(MAX_INFO + 1);
    localparam logic [ICW-1:0] INFO_ONE   = ICW'(1);
    localparam logic [3:0]     ADDR_LIMIT = 4'(MAX_ADDRS);

    localparam logic [2:0] PH_ADDR = 3'd0;
    localparam logic [2:0] PH_CTRL = 3'd1;
    localparam logic [2:0] PH_PID  = 3'd2;
    localparam logic [2:0] PH_INFO = 3'd3;
    localparam logic [2:0] PH_HALT = 3'd4;

    localparam int unsigned QDEPTH = 4;
    localparam logic [2:0]  QROOM  = 3'(QDEPTH - 2);

    logic [7:0]     dly0_reg, dly0_next;
    logic [7:0]     dly1_reg, dly1_next;
    logic [1:0]     fill_reg, fill_next;
    logic [15:0]    crc_reg, crc_next;
    logic [4:0]     len_reg, len_next;
    logic [2:0]     phase_reg, phase_next;
    logic [3:0]     addr_count_reg, addr_count_next;
    logic [2:0]     addr_pos_reg, addr_pos_next;
    logic           saw_last_reg, saw_last_next;
    logic [ICW-1:0] info_count_reg, info_count_next;

    ax25fd_pkg::result_t queue_reg [QDEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;

    ax25fd_pkg::result_t pay_item, st_item, head;
    logic        pay_valid, st_valid;
    logic [3:0]  addr_inc;
    logic [7:0]  pb;
    logic [15:0] stored_check;
    logic        accept, pop;
    logic [1:0]  st_slot;
    logic [1:0]  push_cnt;

    assign accept = byte_chan.valid && byte_chan.ready;
    assign byte_chan.ready = (count_reg <= QROOM);
    assign pb = dly0_reg;
    assign addr_inc = addr_count_reg + 4'd1;

    always_comb
    begin
        dly0_next       = dly0_reg;
        dly1_next       = dly1_reg;
        fill_next       = fill_reg;
        crc_next        = crc_reg;
        phase_next      = phase_reg;
        addr_count_next = addr_count_reg;
        addr_pos_next   = addr_pos_reg;
        saw_last_next   = saw_last_reg;
        info_count_next = info_count_reg;
        pay_item        = '0;
        pay_valid       = 1'b0;
        st_item         = '0;
        st_valid        = 1'b0;
        stored_check    = '0;

        len_next = (len_reg == ax25fd_pkg::MIN_FRAME_BYTES) ? len_reg : len_reg + 5'd1;

        if (fill_reg == 2'd2)
        begin
            // The oldest held byte is payload: it enters the CRC and is classified.
            dly0_next = dly1_reg;
            dly1_next = byte_chan.data_byte;
            crc_next  = ax25fd_pkg::crc_byte(crc_reg, pb);
            case (phase_reg)
                PH_ADDR:
                begin
                    pay_valid = 1'b1;
                    pay_item.addr_index = addr_count_reg;
                    if (addr_pos_reg < 3'd6)
                    begin
                        pay_item.kind  = ax25fd_pkg::KIND_CALL;
                        pay_item.value = {1'b0, pb[7:1]};
                        addr_pos_next  = addr_pos_reg + 3'd1;
                    end
                    else
                    begin
                        pay_item.kind      = ax25fd_pkg::KIND_SSID;
                        pay_item.value     = pb;
                        pay_item.ssid      = pb[4:1];
                        pay_item.repeated  = pb[7];
                        pay_item.addr_last = pb[0];
                        addr_pos_next      = 3'd0;
                        addr_count_next    = addr_inc;
                        if (pb[0])
                        begin
                            saw_last_next = 1'b1;
                            phase_next    = (addr_inc < 4'd2) ? PH_HALT : PH_CTRL;
                        end
                        else if (addr_inc >= ADDR_LIMIT)
                        begin
                            phase_next = PH_HALT;
                        end
                    end
                end
                PH_CTRL:
                begin
                    pay_valid      = 1'b1;
                    pay_item.kind  = ax25fd_pkg::KIND_CTRL;
                    pay_item.value = pb;
                    phase_next     = PH_PID;
                end
                PH_PID:
                begin
                    pay_valid      = 1'b1;
                    pay_item.kind  = ax25fd_pkg::KIND_PID;
                    pay_item.value = pb;
                    phase_next     = PH_INFO;
                end
                PH_INFO:
                begin
                    if (info_count_reg < INFO_LIMIT)
                    begin
                        pay_valid      = 1'b1;
                        pay_item.kind  = ax25fd_pkg::KIND_INFO;
                        pay_item.value = pb;
                    end
                    if (info_count_reg < INFO_SAT)
                    begin
                        info_count_next = info_count_reg + INFO_ONE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (fill_reg == 2'd0)
        begin
            dly0_next = byte_chan.data_byte;
            fill_next = 2'd1;
        end
        else
        begin
            dly1_next = byte_chan.data_byte;
            fill_next = 2'd2;
        end

        pay_item.run_last = !byte_chan.frame_end;

        if (byte_chan.frame_end)
        begin
            stored_check = {dly1_next, dly0_next};
            st_valid     = 1'b1;
            st_item.kind = ax25fd_pkg::KIND_STATUS;
            if (len_next < ax25fd_pkg::MIN_FRAME_BYTES)
                st_item.status = ax25fd_pkg::ST_TOO_SHORT;
            else if ((crc_next ^ ax25fd_pkg::CRC_XOR) != stored_check)
                st_item.status = ax25fd_pkg::ST_BAD_CHECK;
            else if (!saw_last_next || addr_count_next < 4'd2)
                st_item.status = ax25fd_pkg::ST_BAD_ADDR;
            else if (phase_next == PH_CTRL || phase_next == PH_PID)
                st_item.status = ax25fd_pkg::ST_NO_CTRL;
            else if (info_count_next > INFO_LIMIT)
                st_item.status = ax25fd_pkg::ST_INFO_LONG;
            else
                st_item.status = ax25fd_pkg::ST_OK;
            st_item.addr_total  = addr_count_next;
            st_item.info_length = 9'(info_count_next);
            st_item.run_last    = 1'b1;

            // The frame is done: everything returns to its start values.
            dly0_next       = 8'd0;
            dly1_next       = 8'd0;
            fill_next       = 2'd0;
            crc_next        = ax25fd_pkg::CRC_INIT;
            len_next        = 5'd0;
            phase_next      = PH_ADDR;
            addr_count_next = 4'd0;
            addr_pos_next   = 3'd0;
            saw_last_next   = 1'b0;
            info_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dly0_reg       <= 8'd0;
            dly1_reg       <= 8'd0;
            fill_reg       <= 2'd0;
            crc_reg        <= ax25fd_pkg::CRC_INIT;
            len_reg        <= 5'd0;
            phase_reg      <= PH_ADDR;
            addr_count_reg <= 4'd0;
            addr_pos_reg   <= 3'd0;
            saw_last_reg   <= 1'b0;
            info_count_reg <= '0;
        end
        else if (accept)
        begin
            dly0_reg       <= dly0_next;
            dly1_reg       <= dly1_next;
            fill_reg       <= fill_next;
            crc_reg        <= crc_next;
            len_reg        <= len_next;
            phase_reg      <= phase_next;
            addr_count_reg <= addr_count_next;
            addr_pos_reg   <= addr_pos_next;
            saw_last_reg   <= saw_last_next;
            info_count_reg <= info_count_next;
        end
    end

    // Result queue: up to two writes per accepted byte, one read per output transfer.
    assign pop      = item_chan.valid && item_chan.ready;
    assign st_slot  = pay_valid ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
    assign push_cnt = accept ? ({1'b0, pay_valid} + {1'b0, st_valid}) : 2'd0;

    always_ff @(posedge clk)
    begin
        if (accept && pay_valid)
            queue_reg[wr_ptr_reg] <= pay_item;
        if (accept && st_valid)
            queue_reg[st_slot] <= st_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_cnt;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + {1'b0, push_cnt} - {2'b00, pop};
        end
    end

    assign head = queue_reg[rd_ptr_reg];

    assign item_chan.valid       = (count_reg != 3'd0);
    assign item_chan.kind        = head.kind;
    assign item_chan.value       = head.value;
    assign item_chan.addr_index  = head.addr_index;
    assign item_chan.ssid        = head.ssid;
    assign item_chan.repeated    = head.repeated;
    assign item_chan.addr_last   = head.addr_last;
    assign item_chan.status      = head.status;
    assign item_chan.addr_total  = head.addr_total;
    assign item_chan.info_length = head.info_length;
    assign item_chan.run_last    = head.run_last;

endmodule

>>> rtl/core/ax25fd_checker.sv
// Port-level checker for the AX.25 frame decoder and its bind statement.
`include "ax25_frame_decoder_assert.svh"

module ax25fd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] kind,
    input logic [7:0] value,
    input logic [2:0] status,
    input logic [3:0] addr_total,
    input logic [8:0] info_length,
    input logic       run_last
);

    // A waiting item's kind, value and run_last must not change until it is taken.
    `AX25FD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(value) && $stable(run_last), "result item changed while stalled")

    // The status item always closes the results of its byte.
    `AX25FD_ASSERT_NOW(a_status_last, out_valid && kind == ax25fd_pkg::KIND_STATUS, run_last, "status item without run_last")

    // Only the status item carries status fields.
    `AX25FD_ASSERT_NOW(a_fields_clear, out_valid && kind != ax25fd_pkg::KIND_STATUS, status == 3'd0 && addr_total == 4'd0 && info_length == 9'd0, "status fields set on a data item")

    // An item that does not close its byte is followed at once by the frame status.
    `AX25FD_ASSERT_NEXT(a_status_follows, out_valid && out_ready && !run_last, out_valid && kind == ax25fd_pkg::KIND_STATUS, "frame status did not follow")

endmodule

bind ax25_frame_decoder ax25fd_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (item_chan.valid),
    .out_ready   (item_chan.ready),
    .kind        (item_chan.kind),
    .value       (item_chan.value),
    .status      (item_chan.status),
    .addr_total  (item_chan.addr_total),
    .info_length (item_chan.info_length),
    .run_last    (item_chan.run_last)
);
